FILE: design/olir_pkg.sv
package olir_pkg;

	localparam int DEPTH_DEF = 16;

	localparam logic [1:0] ACT_APPEND = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_BEYOND    = 2'd3;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] value;
		logic [3:0]         position;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] read_value;
		logic [4:0]         entry_count;
	} rsp_t;

endpackage

FILE: design/olir_ram.sv
module olir_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = olir_pkg::DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/ordered_list_insert_remove_unit.sv
// Channel | Beat type        | Handshake           | Role
// req     | olir_pkg::req_t  | req_valid/req_stall | request: action, value, position
// rsp     | olir_pkg::rsp_t  | rsp_valid/rsp_stall | result: status, read value, count
//
// Append, unused actions and reads beyond count load the result register on acceptance;
// other reads first pass through S_READ to take the data from the entry RAM.
// Remove does one compare per entry, up to the match, against the stored word read from
// the entry RAM, then one move per later entry one place down through the same read port.
// req_stall is high from acceptance until the result is loaded into the rsp register.
// A stalled rsp beat holds the block in its response state; entry count resets to zero.
module ordered_list_insert_remove_unit #(
	parameter int DEPTH = olir_pkg::DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  olir_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output olir_pkg::rsp_t rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam int XW = (CW > 4) ? CW : 4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_SCAN,
		S_SHIFT,
		S_RESP
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  rd_ptr_q;
	logic [AW-1:0]  cmp_ptr_q;
	logic [AW-1:0]  wr_ptr_q;
	logic           vld_q;
	logic [31:0]    value_q;
	olir_pkg::rsp_t res_q;
	olir_pkg::rsp_t rsp_q;
	logic           rsp_valid_q;

	logic          accept;
	logic          issue;
	logic          hit;
	logic          beyond;
	logic          has_room;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [31:0]   ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [31:0]   ram_rdata;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign issue    = ((state_q == S_SCAN) || (state_q == S_SHIFT)) && (rd_ptr_q < count_q);
	assign hit      = vld_q && (ram_rdata == value_q);
	assign beyond   = XW'(req.position) >= XW'(count_q);
	assign has_room = count_q < CW'(DEPTH);

	assign ram_re    = (accept && (req.action == olir_pkg::ACT_READ) && !beyond) || issue;
	assign ram_raddr = (state_q == S_IDLE) ? AW'(req.position) : AW'(rd_ptr_q);
	assign ram_we    = (accept && (req.action == olir_pkg::ACT_APPEND) && has_room) ||
	                   ((state_q == S_SHIFT) && vld_q);
	assign ram_waddr = (state_q == S_IDLE) ? AW'(count_q) : wr_ptr_q;
	assign ram_wdata = (state_q == S_IDLE) ? 32'(req.value) : ram_rdata;

	olir_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_ptr_q    <= '0;
			cmp_ptr_q   <= '0;
			wr_ptr_q    <= '0;
			vld_q       <= 1'b0;
			value_q     <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= rsp_valid_q && rsp_stall;
			vld_q       <= issue;
			if (issue) begin
				rd_ptr_q  <= rd_ptr_q + CW'(1);
				cmp_ptr_q <= AW'(rd_ptr_q);
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						value_q <= 32'(req.value);
						case (req.action)
							olir_pkg::ACT_APPEND: begin
								if (has_room) begin
									count_q <= count_q + CW'(1);
									res_q   <= '{olir_pkg::ST_DONE, 32'sd0,
									             5'(count_q + CW'(1))};
								end else begin
									res_q <= '{olir_pkg::ST_FULL, 32'sd0, 5'(count_q)};
								end
								state_q <= S_RESP;
							end
							olir_pkg::ACT_REMOVE: begin
								if (count_q == '0) begin
									res_q   <= '{olir_pkg::ST_NOT_FOUND, 32'sd0, 5'(count_q)};
									state_q <= S_RESP;
								end else begin
									rd_ptr_q <= '0;
									state_q  <= S_SCAN;
								end
							end
							olir_pkg::ACT_READ: begin
								if (beyond) begin
									res_q   <= '{olir_pkg::ST_BEYOND, 32'sd0, 5'(count_q)};
									state_q <= S_RESP;
								end else begin
									state_q <= S_READ;
								end
							end
							default: begin
								res_q   <= '{olir_pkg::ST_DONE, 32'sd0, 5'(count_q)};
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_READ: begin
					res_q   <= '{olir_pkg::ST_DONE, $signed(ram_rdata), 5'(count_q)};
					state_q <= S_RESP;
				end
				S_SCAN: begin
					if (hit) begin
						wr_ptr_q <= cmp_ptr_q;
						state_q  <= S_SHIFT;
					end else if (!vld_q && !issue) begin
						res_q   <= '{olir_pkg::ST_NOT_FOUND, 32'sd0, 5'(count_q)};
						state_q <= S_RESP;
					end
				end
				S_SHIFT: begin
					if (vld_q) begin
						wr_ptr_q <= wr_ptr_q + AW'(1);
					end else if (!issue) begin
						count_q <= count_q - CW'(1);
						res_q   <= '{olir_pkg::ST_DONE, 32'sd0, 5'(count_q - CW'(1))};
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
